FILE: hdl/ght_pkg.sv
package ght_pkg;

    localparam int DEF_ROWS      = 1024;
    localparam int DEF_WORD_BITS = 16;
    localparam int DEF_GEN_BITS  = 16;

    localparam int CMD_BITS    = 2;
    localparam int STATUS_BITS = 2;
    localparam int Q_DEPTH     = 2;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_ADD    = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_SET    = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_STALE = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // head of the command queue as seen by the back end
    typedef struct packed {
        logic valid;
        t_cmd cmd;
        logic slot_over;
        logic unstorable;
    } t_qhead;

    // back end to front end
    typedef struct packed {
        logic pop;
        logic clearing;
    } t_bctl;

endpackage

FILE: hdl/ght_ram.sv
module ght_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/ght_front.sv
module ght_front #(
    parameter int ROWS      = ght_pkg::DEF_ROWS,
    parameter int WORD_BITS = ght_pkg::DEF_WORD_BITS,
    parameter int GEN_BITS  = ght_pkg::DEF_GEN_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  ght_pkg::t_cmd             i_cmd,
    input  logic [$clog2(ROWS)-1:0]   i_slot,
    input  logic [GEN_BITS-1:0]       i_gen,
    input  logic [WORD_BITS-1:0]      i_data,
    output ght_pkg::t_qhead           o_head,
    output logic [$clog2(ROWS)-1:0]   o_slot,
    output logic [GEN_BITS-1:0]       o_gen,
    output logic [WORD_BITS-1:0]      o_data,
    input  ght_pkg::t_bctl            i_bctl
);

    import ght_pkg::*;

    localparam int SLOT_BITS = $clog2(ROWS);
    localparam int CNT_BITS  = $clog2(ROWS + 1);
    localparam int PTR_BITS  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCNT_BITS = $clog2(Q_DEPTH + 1);

    t_cmd                 r_q_cmd   [Q_DEPTH];
    logic                 r_q_over  [Q_DEPTH];
    logic                 r_q_unst  [Q_DEPTH];
    logic [SLOT_BITS-1:0] r_q_slot  [Q_DEPTH];
    logic [GEN_BITS-1:0]  r_q_gen   [Q_DEPTH];
    logic [WORD_BITS-1:0] r_q_data  [Q_DEPTH];

    logic [PTR_BITS-1:0]  r_wptr, n_wptr;
    logic [PTR_BITS-1:0]  r_rptr, n_rptr;
    logic [QCNT_BITS-1:0] r_count, n_count;

    logic push;
    logic pop;

    assign o_ready = (r_count != QCNT_BITS'(Q_DEPTH)) && !i_bctl.clearing;
    assign push    = i_valid && o_ready;
    assign pop     = i_bctl.pop && (r_count != '0);

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (push) begin
            n_wptr = (r_wptr == PTR_BITS'(Q_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (pop) begin
            n_rptr = (r_rptr == PTR_BITS'(Q_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_cmd[r_wptr]  <= i_cmd;
            r_q_over[r_wptr] <= (CNT_BITS'(i_slot) >= CNT_BITS'(ROWS));
            r_q_unst[r_wptr] <= &i_data;
            r_q_slot[r_wptr] <= i_slot;
            r_q_gen[r_wptr]  <= i_gen;
            r_q_data[r_wptr] <= i_data;
        end
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    assign o_head.valid      = (r_count != '0);
    assign o_head.cmd        = r_q_cmd[r_rptr];
    assign o_head.slot_over  = r_q_over[r_rptr];
    assign o_head.unstorable = r_q_unst[r_rptr];
    assign o_slot            = r_q_slot[r_rptr];
    assign o_gen             = r_q_gen[r_rptr];
    assign o_data            = r_q_data[r_rptr];

endmodule

FILE: hdl/ght_back.sv
module ght_back #(
    parameter int ROWS      = ght_pkg::DEF_ROWS,
    parameter int WORD_BITS = ght_pkg::DEF_WORD_BITS,
    parameter int GEN_BITS  = ght_pkg::DEF_GEN_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  ght_pkg::t_qhead         i_head,
    input  logic [$clog2(ROWS)-1:0] i_q_slot,
    input  logic [GEN_BITS-1:0]     i_q_gen,
    input  logic [WORD_BITS-1:0]    i_q_data,
    output ght_pkg::t_bctl          o_bctl,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [$clog2(ROWS)-1:0] o_out_slot,
    output logic [GEN_BITS-1:0]     o_out_gen,
    output logic [WORD_BITS-1:0]    o_out_word,
    output ght_pkg::t_status        o_out_status
);

    import ght_pkg::*;

    localparam int IDX_BITS = $clog2(ROWS);
    localparam int CNT_BITS = $clog2(ROWS + 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_POP,
        S_READ
    } t_state;

    t_state r_state, n_state;
    logic [IDX_BITS-1:0]  r_clr, n_clr;
    logic [CNT_BITS-1:0]  r_free, n_free;
    logic [CNT_BITS-1:0]  r_used, n_used;
    logic [IDX_BITS-1:0]  r_idx, n_idx;
    t_cmd                 r_cmd, n_cmd;
    logic [GEN_BITS-1:0]  r_gen, n_gen;
    logic [WORD_BITS-1:0] r_data, n_data;

    logic                 r_ovalid, n_ovalid;
    logic [IDX_BITS-1:0]  r_oslot, n_oslot;
    logic [GEN_BITS-1:0]  r_ogen, n_ogen;
    logic [WORD_BITS-1:0] r_oword, n_oword;
    t_status              r_ostat, n_ostat;

    logic                 row_re;
    logic [IDX_BITS-1:0]  row_raddr;
    logic                 word_we;
    logic                 gen_we;
    logic [IDX_BITS-1:0]  row_waddr;
    logic [WORD_BITS-1:0] word_wdata;
    logic [GEN_BITS-1:0]  gen_wdata;
    logic [WORD_BITS-1:0] word_rdata;
    logic [GEN_BITS-1:0]  gen_rdata;

    logic                 stk_re;
    logic [IDX_BITS-1:0]  stk_raddr;
    logic                 stk_we;
    logic [IDX_BITS-1:0]  stk_waddr;
    logic [IDX_BITS-1:0]  stk_rdata;

    logic out_free;
    logic pop;

    assign out_free = !r_ovalid || i_out_ready;

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_free     = r_free;
        n_used     = r_used;
        n_idx      = r_idx;
        n_cmd      = r_cmd;
        n_gen      = r_gen;
        n_data     = r_data;
        n_ovalid   = r_ovalid && !i_out_ready;
        n_oslot    = r_oslot;
        n_ogen     = r_ogen;
        n_oword    = r_oword;
        n_ostat    = r_ostat;
        row_re     = 1'b0;
        row_raddr  = r_idx;
        word_we    = 1'b0;
        gen_we     = 1'b0;
        row_waddr  = r_idx;
        word_wdata = '0;
        gen_wdata  = '0;
        stk_re     = 1'b0;
        stk_raddr  = IDX_BITS'(r_free - 1'b1);
        stk_we     = 1'b0;
        stk_waddr  = IDX_BITS'(r_free);
        pop        = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                word_we   = 1'b1;
                gen_we    = 1'b1;
                row_waddr = r_clr;
                if (r_clr == IDX_BITS'(ROWS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_head.valid && out_free) begin
                    pop    = 1'b1;
                    n_cmd  = i_head.cmd;
                    n_gen  = i_q_gen;
                    n_data = i_q_data;
                    case (i_head.cmd)
                        CMD_ADD: begin
                            if (r_free == '0 && r_used >= CNT_BITS'(ROWS)) begin
                                n_ovalid = 1'b1;
                                n_oslot  = '0;
                                n_ogen   = '0;
                                n_oword  = '0;
                                n_ostat  = ST_FULL;
                            end else if (i_head.unstorable) begin
                                n_ovalid = 1'b1;
                                n_oslot  = '0;
                                n_ogen   = '0;
                                n_oword  = '0;
                                n_ostat  = ST_RANGE;
                            end else if (r_free != '0) begin
                                stk_re  = 1'b1;
                                n_free  = r_free - 1'b1;
                                n_state = S_POP;
                            end else begin
                                n_idx     = IDX_BITS'(r_used);
                                row_re    = 1'b1;
                                row_raddr = IDX_BITS'(r_used);
                                n_used    = r_used + 1'b1;
                                n_state   = S_READ;
                            end
                        end
                        CMD_LOOKUP: begin
                            if (CNT_BITS'(i_q_slot) >= r_used || i_head.slot_over) begin
                                n_ovalid = 1'b1;
                                n_oslot  = i_q_slot;
                                n_ogen   = '0;
                                n_oword  = '0;
                                n_ostat  = ST_RANGE;
                            end else begin
                                n_idx     = i_q_slot;
                                row_re    = 1'b1;
                                row_raddr = i_q_slot;
                                n_state   = S_READ;
                            end
                        end
                        default: begin
                            if (i_head.slot_over) begin
                                n_ovalid = 1'b1;
                                n_oslot  = i_q_slot;
                                n_ogen   = '0;
                                n_oword  = '0;
                                n_ostat  = ST_RANGE;
                            end else begin
                                n_idx     = i_q_slot;
                                row_re    = 1'b1;
                                row_raddr = i_q_slot;
                                n_state   = S_READ;
                            end
                        end
                    endcase
                end
            end
            S_POP: begin
                n_idx     = stk_rdata;
                row_re    = 1'b1;
                row_raddr = stk_rdata;
                n_state   = S_READ;
            end
            S_READ: begin
                n_state  = S_IDLE;
                n_ovalid = 1'b1;
                n_oslot  = r_idx;
                n_ogen   = gen_rdata;
                n_oword  = '0;
                n_ostat  = ST_OK;
                case (r_cmd)
                    CMD_ADD: begin
                        word_we    = 1'b1;
                        word_wdata = r_data + 1'b1;
                    end
                    CMD_LOOKUP: begin
                        if (word_rdata != '0 && gen_rdata == r_gen) begin
                            n_oword = word_rdata;
                        end else begin
                            n_ostat = ST_STALE;
                        end
                    end
                    CMD_REMOVE: begin
                        if (r_idx == '0 || word_rdata == '0 || gen_rdata != r_gen) begin
                            n_ostat = ST_STALE;
                        end else begin
                            word_we   = 1'b1;
                            gen_we    = 1'b1;
                            gen_wdata = gen_rdata + 1'b1;
                            n_ogen    = gen_rdata + 1'b1;
                            n_oword   = word_rdata;
                            if (r_free < CNT_BITS'(ROWS)) begin
                                stk_we = 1'b1;
                                n_free = r_free + 1'b1;
                            end
                        end
                    end
                    default: begin
                        word_we    = 1'b1;
                        word_wdata = r_data;
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_cmd   <= n_cmd;
        r_gen   <= n_gen;
        r_data  <= n_data;
        r_oslot <= n_oslot;
        r_ogen  <= n_ogen;
        r_oword <= n_oword;
        r_ostat <= n_ostat;
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_free   <= '0;
            r_used   <= CNT_BITS'(1);
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_free   <= n_free;
            r_used   <= n_used;
            r_ovalid <= n_ovalid;
        end
    end

    ght_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (ROWS)
    ) u_word_ram (
        .i_clk   (i_clk),
        .i_we    (word_we),
        .i_waddr (row_waddr),
        .i_wdata (word_wdata),
        .i_re    (row_re),
        .i_raddr (row_raddr),
        .o_rdata (word_rdata)
    );

    ght_ram #(
        .WIDTH (GEN_BITS),
        .DEPTH (ROWS)
    ) u_gen_ram (
        .i_clk   (i_clk),
        .i_we    (gen_we),
        .i_waddr (row_waddr),
        .i_wdata (gen_wdata),
        .i_re    (row_re),
        .i_raddr (row_raddr),
        .o_rdata (gen_rdata)
    );

    ght_ram #(
        .WIDTH (IDX_BITS),
        .DEPTH (ROWS)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (r_idx),
        .i_re    (stk_re),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    assign o_bctl.pop      = pop;
    assign o_bctl.clearing = (r_state == S_CLEAR);
    assign o_out_valid     = r_ovalid;
    assign o_out_slot      = r_oslot;
    assign o_out_gen       = r_ogen;
    assign o_out_word      = r_oword;
    assign o_out_status    = r_ostat;

endmodule

FILE: hdl/generational_handle_table_top.sv
// channel   direction  tdata (low bit up)                  tuser
// s_axis    in         slot, generation, data_word         cmd
// m_axis    out        out_slot, out_generation, out_word  status
//
// after reset a clearing pass writes every row to zero, with tready low
// add from the free stack does a stack read, then a row read, then the update
// other commands needing a row, and an add of a fresh row, do a row read, then the update
// add on a full table, bad words and range errors finish without a row read
// a two-word queue keeps accepting until full while a result waits on m_axis tready
module generational_handle_table_top #(
    parameter int ROWS      = ght_pkg::DEF_ROWS,
    parameter int WORD_BITS = ght_pkg::DEF_WORD_BITS,
    parameter int GEN_BITS  = ght_pkg::DEF_GEN_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // slot, generation, data_word
    input  logic [(($clog2(ROWS) + GEN_BITS + WORD_BITS + 7) / 8) * 8 - 1:0]
                                                  i_s_axis_tdata,
    // cmd
    input  logic [ght_pkg::CMD_BITS-1:0]          i_s_axis_tuser,
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // out_slot, out_generation, out_word
    output logic [(($clog2(ROWS) + GEN_BITS + WORD_BITS + 7) / 8) * 8 - 1:0]
                                                  o_m_axis_tdata,
    // status
    output logic [ght_pkg::STATUS_BITS-1:0]       o_m_axis_tuser
);

    import ght_pkg::*;

    localparam int SLOT_BITS = $clog2(ROWS);
    localparam int DATA_W    = ((SLOT_BITS + GEN_BITS + WORD_BITS + 7) / 8) * 8;

    t_qhead               head;
    t_bctl                bctl;
    logic [SLOT_BITS-1:0] q_slot;
    logic [GEN_BITS-1:0]  q_gen;
    logic [WORD_BITS-1:0] q_data;
    logic [SLOT_BITS-1:0] out_slot;
    logic [GEN_BITS-1:0]  out_gen;
    logic [WORD_BITS-1:0] out_word;
    t_status              out_status;

    ght_front #(
        .ROWS      (ROWS),
        .WORD_BITS (WORD_BITS),
        .GEN_BITS  (GEN_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_cmd   (t_cmd'(i_s_axis_tuser)),
        .i_slot  (i_s_axis_tdata[SLOT_BITS-1:0]),
        .i_gen   (i_s_axis_tdata[SLOT_BITS+GEN_BITS-1:SLOT_BITS]),
        .i_data  (i_s_axis_tdata[SLOT_BITS+GEN_BITS+WORD_BITS-1:SLOT_BITS+GEN_BITS]),
        .o_head  (head),
        .o_slot  (q_slot),
        .o_gen   (q_gen),
        .o_data  (q_data),
        .i_bctl  (bctl)
    );

    ght_back #(
        .ROWS      (ROWS),
        .WORD_BITS (WORD_BITS),
        .GEN_BITS  (GEN_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_q_slot     (q_slot),
        .i_q_gen      (q_gen),
        .i_q_data     (q_data),
        .o_bctl       (bctl),
        .o_out_valid  (o_m_axis_tvalid),
        .i_out_ready  (i_m_axis_tready),
        .o_out_slot   (out_slot),
        .o_out_gen    (out_gen),
        .o_out_word   (out_word),
        .o_out_status (out_status)
    );

    assign o_m_axis_tdata = DATA_W'({out_word, out_gen, out_slot});
    assign o_m_axis_tuser = out_status;

endmodule

FILE: hdl/ght_checker.sv
module ght_checker #(
    parameter int ROWS      = ght_pkg::DEF_ROWS,
    parameter int WORD_BITS = ght_pkg::DEF_WORD_BITS,
    parameter int GEN_BITS  = ght_pkg::DEF_GEN_BITS
) (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_s_axis_tvalid,
    input logic                                  o_s_axis_tready,
    input logic [(($clog2(ROWS) + GEN_BITS + WORD_BITS + 7) / 8) * 8 - 1:0]
                                                 i_s_axis_tdata,
    input logic [ght_pkg::CMD_BITS-1:0]          i_s_axis_tuser,
    input logic                                  o_m_axis_tvalid,
    input logic                                  i_m_axis_tready,
    input logic [(($clog2(ROWS) + GEN_BITS + WORD_BITS + 7) / 8) * 8 - 1:0]
                                                 o_m_axis_tdata,
    input logic [ght_pkg::STATUS_BITS-1:0]       o_m_axis_tuser
);

    import ght_pkg::*;

    localparam int SLOT_BITS = $clog2(ROWS);
    localparam int GEN_LO    = SLOT_BITS;
    localparam int WORD_LO   = SLOT_BITS + GEN_BITS;

    logic [GEN_BITS-1:0]  m_gen;
    logic [WORD_BITS-1:0] m_word;
    logic                 s_word_seen;

    assign m_gen       = o_m_axis_tdata[WORD_LO-1:GEN_LO];
    assign m_word      = o_m_axis_tdata[WORD_LO+WORD_BITS-1:WORD_LO];
    assign s_word_seen = i_s_axis_tvalid && (i_s_axis_tuser != '0 || i_s_axis_tdata != '0);

    // reset starts the clearing pass with nothing pending
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && !o_s_axis_tready)
        else $error("ready or valid high right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == ST_FULL |-> o_m_axis_tdata == '0)
        else $error("full table result carries data");

    a_error_no_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != ST_OK |-> m_word == '0)
        else $error("error result returns a stored word");

    a_range_no_gen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == ST_RANGE |-> m_gen == '0 || s_word_seen)
        else $error("range error returns a generation");

endmodule

bind generational_handle_table_top ght_checker #(
    .ROWS      (ROWS),
    .WORD_BITS (WORD_BITS),
    .GEN_BITS  (GEN_BITS)
) u_ght_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
